[sv/sorted_timeout_queue_macros.svh]
// Assertion macros of the checker file of the sorted timeout queue.
`ifndef SORTED_TIMEOUT_QUEUE_MACROS_SVH
`define SORTED_TIMEOUT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define STQ_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted timeout queue check failed");

// Next-cycle implication, disabled while reset is high.
`define STQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted timeout queue check failed");

`endif

[sv/stq_pkg.sv]
// Types and constants of the sorted timeout queue.
`default_nettype none

package stq_pkg;

   localparam int ID_PORT_W   = 16;
   localparam int TIME_PORT_W = 32;
   localparam int STATUS_W    = 3;
   localparam int MAX_RESULTS = 32;
   localparam int POP_CNT_W   = $clog2(MAX_RESULTS);

   localparam logic [POP_CNT_W-1:0] LAST_POP = POP_CNT_W'(MAX_RESULTS - 1);
   localparam logic [POP_CNT_W-1:0] POP_ONE  = POP_CNT_W'(1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_ADJUST = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EXPIRED   = 3'd3,
      ST_NOTHING   = 3'd4,
      ST_DUPLICATE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CMD_HOLD   = 3'd0,
      CMD_EVAL   = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_POP    = 3'd4
   } cell_cmd_type;

endpackage

`default_nettype wire

[sv/stq_cell.sv]
// One slot of the sorted timer chain: a timer, its compare flags and neighbor moves.
`default_nettype none

module stq_cell #(
   parameter int ID_BITS   = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire stq_pkg::cell_cmd_type cmd,
   input  wire logic [ID_BITS-1:0]    key_id,
   input  wire logic [TIME_BITS-1:0]  key_time,
   input  wire logic                  left_valid,
   input  wire logic                  left_ge,
   input  wire logic [TIME_BITS-1:0]  left_exp,
   input  wire logic [ID_BITS-1:0]    left_id,
   input  wire logic                  right_valid,
   input  wire logic [TIME_BITS-1:0]  right_exp,
   input  wire logic [ID_BITS-1:0]    right_id,
   input  wire logic                  seen,
   output logic                       valid,
   output logic                       ge,
   output logic                       match,
   output logic [TIME_BITS-1:0]       exp,
   output logic [ID_BITS-1:0]         id
);

   logic                 valid_ff, valid_in;
   logic                 ge_ff, ge_in;
   logic                 match_ff, match_in;
   logic [TIME_BITS-1:0] exp_ff, exp_in;
   logic [ID_BITS-1:0]   id_ff, id_in;

   always_comb begin
      valid_in = valid_ff;
      ge_in    = ge_ff;
      match_in = match_ff;
      exp_in   = exp_ff;
      id_in    = id_ff;
      case (cmd)
         stq_pkg::CMD_EVAL: begin
            // An empty slot counts as later than any key, so an insert lands
            // in the first empty slot when every live timer is earlier.
            ge_in    = !valid_ff || (exp_ff >= key_time);
            match_in = valid_ff && (id_ff == key_id);
         end
         stq_pkg::CMD_INSERT: begin
            if (left_ge) begin
               valid_in = left_valid;
               exp_in   = left_exp;
               id_in    = left_id;
            end else if (ge_ff) begin
               valid_in = 1'b1;
               exp_in   = key_time;
               id_in    = key_id;
            end
         end
         stq_pkg::CMD_REMOVE: begin
            if (seen) begin
               valid_in = right_valid;
               exp_in   = right_exp;
               id_in    = right_id;
            end
         end
         stq_pkg::CMD_POP: begin
            valid_in = right_valid;
            exp_in   = right_exp;
            id_in    = right_id;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ge_ff    <= ge_in;
      match_ff <= match_in;
      exp_ff   <= exp_in;
      id_ff    <= id_in;
   end

   assign valid = valid_ff;
   assign ge    = ge_ff;
   assign match = match_ff;
   assign exp   = exp_ff;
   assign id    = id_ff;

endmodule

`default_nettype wire

[sv/sorted_timeout_queue.sv]
// Top level of the sorted timeout queue: a chain of timer cells and its sequencer.
//
// The queue keeps up to CAPACITY connection timers in ascending order of
// expiry, slot 0 expiring first. Items arrive on the req_ channel (insert,
// remove, adjust or tick) and results leave on the rsp_ channel; each
// channel moves an item at a clock edge where valid is high and stall is low.
// Insert, remove and adjust give exactly one result. Tick gives one result
// per expired timer, oldest first, up to 32 per tick, with rsp_last marking
// the final one, or a single nothing_expired result.
// The block works on one item at a time. A remove or an insert goes through
// the compare, decide and shift passes of the cell chain before its result
// is loaded; an adjust adds a second compare and an insert shift after its
// remove shift, and a duplicate, full or not_found answer follows the decide
// pass. A tick pops the head for each result that it loads, shifting the
// whole chain down by one cell. The next item is accepted in the cycle after
// the last result is loaded, even if that result is still waiting.
// Reset empties the chain at once; no clearing pass is needed.
// While rsp_stall is high the result register holds its item and the
// sequencer waits, so no result is lost or repeated.
`default_nettype none

module sorted_timeout_queue #(
   parameter int CAPACITY  = 32,
   parameter int ID_BITS   = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_operation,
   input  wire logic [stq_pkg::ID_PORT_W-1:0]      req_connection_id,
   input  wire logic [stq_pkg::TIME_PORT_W-1:0]    req_expire_time,
   input  wire logic [stq_pkg::TIME_PORT_W-1:0]    req_now_time,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [stq_pkg::STATUS_W-1:0]            rsp_status,
   output logic [stq_pkg::ID_PORT_W-1:0]           rsp_expired_id,
   output logic                                    rsp_last
);

   localparam int IdPortW = stq_pkg::ID_PORT_W;
   localparam int Levels  = $clog2(CAPACITY);

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_EVAL   = 8'b0000_0010,
      S_DECIDE = 8'b0000_0100,
      S_REMOVE = 8'b0000_1000,
      S_REEVAL = 8'b0001_0000,
      S_INSERT = 8'b0010_0000,
      S_POP    = 8'b0100_0000,
      S_REPLY  = 8'b1000_0000
   } state_type;

   state_type                          state_ff, state_in;
   stq_pkg::op_type                    op_ff;
   logic [ID_BITS-1:0]                 key_id_ff;
   logic [TIME_BITS-1:0]               key_exp_ff;
   logic [TIME_BITS-1:0]               now_ff;
   stq_pkg::status_type                reply_ff, reply_in;
   logic [stq_pkg::POP_CNT_W-1:0]      pop_cnt_ff, pop_cnt_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   stq_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [IdPortW-1:0]                 rsp_id_ff, rsp_id_in;
   logic                               rsp_last_ff, rsp_last_in;

   stq_pkg::cell_cmd_type              cell_cmd;
   logic                               req_accept;
   logic                               out_free;
   logic                               found;
   logic                               full;
   logic                               head_expired;
   logic                               next_expired;
   logic                               pop_last;

   // Cell outputs, one entry per slot.
   logic                               cell_valid [CAPACITY];
   logic                               cell_ge    [CAPACITY];
   logic [TIME_BITS-1:0]               cell_exp   [CAPACITY];
   logic [ID_BITS-1:0]                 cell_id    [CAPACITY];
   logic [CAPACITY-1:0]                match_vec;

   // Running OR of the match flags: prefix[Levels][i] is set when the
   // addressed timer sits in slot i or below, so slot i must take its
   // right neighbor during a remove.
   logic [Levels:0][CAPACITY-1:0]      prefix;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   genvar gl, gi;
   assign prefix[0] = match_vec;
   for (gl = 0; gl < Levels; gl++) begin : g_level
      for (gi = 0; gi < CAPACITY; gi++) begin : g_bit
         if (gi >= (1 << gl)) begin : g_or
            assign prefix[gl+1][gi] = prefix[gl][gi] | prefix[gl][gi - (1 << gl)];
         end else begin : g_pass
            assign prefix[gl+1][gi] = prefix[gl][gi];
         end
      end
   end

   // The chain of cells. The head slot sees an empty neighbor on the left,
   // and the last slot sees an empty neighbor on the right.
   for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                 l_valid;
      logic                 l_ge;
      logic [TIME_BITS-1:0] l_exp;
      logic [ID_BITS-1:0]   l_id;
      logic                 r_valid;
      logic [TIME_BITS-1:0] r_exp;
      logic [ID_BITS-1:0]   r_id;

      if (gi == 0) begin : g_first
         assign l_valid = 1'b0;
         assign l_ge    = 1'b0;
         assign l_exp   = '0;
         assign l_id    = '0;
      end else begin : g_left
         assign l_valid = cell_valid[gi-1];
         assign l_ge    = cell_ge[gi-1];
         assign l_exp   = cell_exp[gi-1];
         assign l_id    = cell_id[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_exp   = '0;
         assign r_id    = '0;
      end else begin : g_right
         assign r_valid = cell_valid[gi+1];
         assign r_exp   = cell_exp[gi+1];
         assign r_id    = cell_id[gi+1];
      end

      stq_cell #(
         .ID_BITS   (ID_BITS),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd),
         .key_id      (key_id_ff),
         .key_time    (key_exp_ff),
         .left_valid  (l_valid),
         .left_ge     (l_ge),
         .left_exp    (l_exp),
         .left_id     (l_id),
         .right_valid (r_valid),
         .right_exp   (r_exp),
         .right_id    (r_id),
         .seen        (prefix[Levels][gi]),
         .valid       (cell_valid[gi]),
         .ge          (cell_ge[gi]),
         .match       (match_vec[gi]),
         .exp         (cell_exp[gi]),
         .id          (cell_id[gi])
      );
   end

   assign found = |match_vec;
   assign full  = cell_valid[CAPACITY-1];

   // Because the chain is sorted, the head and its neighbor decide a tick:
   // the head says whether to pop, the neighbor and the pop count whether this pop is the last.
   assign head_expired = cell_valid[0] && (cell_exp[0] <= now_ff);
   assign next_expired = cell_valid[1] && (cell_exp[1] <= now_ff);
   assign pop_last     = !next_expired || (pop_cnt_ff == stq_pkg::LAST_POP);

   always_comb begin
      state_in      = state_ff;
      reply_in      = reply_ff;
      pop_cnt_in    = pop_cnt_ff;
      cell_cmd      = stq_pkg::CMD_HOLD;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pop_cnt_in = '0;
               if (stq_pkg::op_type'(req_operation) == stq_pkg::OP_TICK) begin
                  state_in = S_POP;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         S_EVAL: begin
            cell_cmd = stq_pkg::CMD_EVAL;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (op_ff)
               stq_pkg::OP_INSERT: begin
                  if (found) begin
                     reply_in = stq_pkg::ST_DUPLICATE;
                     state_in = S_REPLY;
                  end else if (full) begin
                     reply_in = stq_pkg::ST_FULL;
                     state_in = S_REPLY;
                  end else begin
                     state_in = S_INSERT;
                  end
               end
               stq_pkg::OP_REMOVE, stq_pkg::OP_ADJUST: begin
                  if (found) begin
                     state_in = S_REMOVE;
                  end else begin
                     reply_in = stq_pkg::ST_NOT_FOUND;
                     state_in = S_REPLY;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_REMOVE: begin
            cell_cmd = stq_pkg::CMD_REMOVE;
            if (op_ff == stq_pkg::OP_ADJUST) begin
               state_in = S_REEVAL;
            end else begin
               reply_in = stq_pkg::ST_OK;
               state_in = S_REPLY;
            end
         end
         S_REEVAL: begin
            // The chain has just closed the gap; compare again for placement.
            cell_cmd = stq_pkg::CMD_EVAL;
            state_in = S_INSERT;
         end
         S_INSERT: begin
            cell_cmd = stq_pkg::CMD_INSERT;
            reply_in = stq_pkg::ST_OK;
            state_in = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = reply_ff;
               rsp_id_in     = IdPortW'(key_id_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (head_expired) begin
                  rsp_status_in = stq_pkg::ST_EXPIRED;
                  rsp_id_in     = IdPortW'(cell_id[0]);
                  rsp_last_in   = pop_last;
                  cell_cmd      = stq_pkg::CMD_POP;
                  pop_cnt_in    = pop_cnt_ff + stq_pkg::POP_ONE;
                  if (pop_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  // Only reached for the first result of a tick.
                  rsp_status_in = stq_pkg::ST_NOTHING;
                  rsp_id_in     = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= stq_pkg::op_type'(req_operation);
         key_id_ff  <= ID_BITS'(req_connection_id);
         key_exp_ff <= TIME_BITS'(req_expire_time);
         now_ff     <= TIME_BITS'(req_now_time);
      end
      reply_ff      <= reply_in;
      pop_cnt_ff    <= pop_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

[sv/stq_checker.sv]
// Port-level checks of the sorted timeout queue and their binding to the top level.
`default_nettype none
`include "sorted_timeout_queue_macros.svh"

module stq_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [stq_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic [stq_pkg::ID_PORT_W-1:0]   rsp_expired_id,
   input wire logic                            rsp_last
);

   logic req_accept;
   logic rsp_hold;

   assign req_accept = req_valid && !req_stall;
   assign rsp_hold   = rsp_valid && rsp_stall;

   // A stalled result stays offered and unchanged.
   `STQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold,
      rsp_valid && $stable(rsp_status) && $stable(rsp_expired_id) && $stable(rsp_last))

   // The queue works on one item at a time.
   `STQ_ASSERT_NEXT(a_one_item, clock, reset, req_accept, req_stall)

   // Only a tick pop may be followed by further results of the same item.
   `STQ_ASSERT_NOW(a_single_last, clock, reset,
      rsp_valid && (rsp_status != stq_pkg::ST_EXPIRED), rsp_last)

   // A tick that finds nothing names no connection.
   `STQ_ASSERT_NOW(a_nothing_id, clock, reset,
      rsp_valid && (rsp_status == stq_pkg::ST_NOTHING), rsp_expired_id == '0)

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (.*);

`default_nettype wire

[test/stq_result_checker.sv]
// Result checker of the sorted timeout queue: keeps its own timer list and compares every result.
module stq_result_checker #(
   parameter int CAPACITY = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic [stq_pkg::ID_PORT_W-1:0]   req_connection_id,
   input  logic [stq_pkg::TIME_PORT_W-1:0] req_expire_time,
   input  logic [stq_pkg::TIME_PORT_W-1:0] req_now_time,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [stq_pkg::STATUS_W-1:0]    rsp_status,
   input  logic [stq_pkg::ID_PORT_W-1:0]   rsp_expired_id,
   input  logic                            rsp_last,
   output int                              mismatches,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      stq_pkg::status_type           status;
      logic [stq_pkg::ID_PORT_W-1:0] conn;
      logic                          last;
   } timer_result_type;

   logic [stq_pkg::TIME_PORT_W-1:0] slot_expiry [CAPACITY];
   logic [stq_pkg::ID_PORT_W-1:0]   slot_conn [CAPACITY];
   int                              slot_used = 0;
   timer_result_type                awaited_results [$];
   int                              mismatch_tally = 0;

   task automatic report_mismatch(input string what);
      $display("[%0t] result mismatch: %s", $time, what);
      mismatch_tally++;
   endtask

   function automatic void expect_result(stq_pkg::status_type status,
                                         logic [stq_pkg::ID_PORT_W-1:0] conn,
                                         logic last);
      timer_result_type entry;
      entry.status = status;
      entry.conn   = conn;
      entry.last   = last;
      awaited_results.push_back(entry);
   endfunction

   function automatic int find_conn(logic [stq_pkg::ID_PORT_W-1:0] conn);
      for (int i = 0; i < slot_used; i++) begin
         if (slot_conn[i] == conn) return i;
      end
      return -1;
   endfunction

   // A new timer goes ahead of every entry with the same expiry.
   function automatic void place_timer(logic [stq_pkg::ID_PORT_W-1:0] conn,
                                       logic [stq_pkg::TIME_PORT_W-1:0] expiry);
      int pos;
      pos = 0;
      while (pos < slot_used && slot_expiry[pos] < expiry) pos++;
      for (int i = slot_used; i > pos; i--) begin
         slot_expiry[i] = slot_expiry[i-1];
         slot_conn[i]   = slot_conn[i-1];
      end
      slot_expiry[pos] = expiry;
      slot_conn[pos]   = conn;
      slot_used++;
   endfunction

   function automatic void update_timer_list(stq_pkg::op_type op,
                                             logic [stq_pkg::ID_PORT_W-1:0] conn,
                                             logic [stq_pkg::TIME_PORT_W-1:0] expiry,
                                             logic [stq_pkg::TIME_PORT_W-1:0] tick_time);
      int pos;
      int pops;
      case (op)
         stq_pkg::OP_INSERT: begin
            if (find_conn(conn) >= 0) begin
               expect_result(stq_pkg::ST_DUPLICATE, conn, 1'b1);
            end else if (slot_used >= CAPACITY) begin
               expect_result(stq_pkg::ST_FULL, conn, 1'b1);
            end else begin
               place_timer(conn, expiry);
               expect_result(stq_pkg::ST_OK, conn, 1'b1);
            end
         end
         stq_pkg::OP_REMOVE, stq_pkg::OP_ADJUST: begin
            pos = find_conn(conn);
            if (pos < 0) begin
               expect_result(stq_pkg::ST_NOT_FOUND, conn, 1'b1);
            end else begin
               for (int i = pos; i + 1 < slot_used; i++) begin
                  slot_expiry[i] = slot_expiry[i+1];
                  slot_conn[i]   = slot_conn[i+1];
               end
               slot_used--;
               if (op == stq_pkg::OP_ADJUST) place_timer(conn, expiry);
               expect_result(stq_pkg::ST_OK, conn, 1'b1);
            end
         end
         default: begin
            pops = 0;
            while (pops < slot_used && pops < stq_pkg::MAX_RESULTS &&
                   slot_expiry[pops] <= tick_time)
               pops++;
            if (pops == 0) begin
               expect_result(stq_pkg::ST_NOTHING, '0, 1'b1);
            end else begin
               for (int i = 0; i < pops; i++)
                  expect_result(stq_pkg::ST_EXPIRED, slot_conn[i], i == pops - 1);
               for (int i = 0; i + pops < slot_used; i++) begin
                  slot_expiry[i] = slot_expiry[i+pops];
                  slot_conn[i]   = slot_conn[i+pops];
               end
               slot_used -= pops;
            end
         end
      endcase
   endfunction

   // Results are checked before the item of the same edge is predicted, so a
   // stray result can never be matched against its own item.
   always @(posedge clock) begin
      timer_result_type oldest;
      if (reset) begin
         slot_used = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d id %h last %b",
                                         rsp_status, rsp_expired_id, rsp_last));
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("status %0d, awaited %s",
                                            rsp_status, oldest.status.name()));
               if (rsp_expired_id !== oldest.conn)
                  report_mismatch($sformatf("id %h, awaited %h", rsp_expired_id, oldest.conn));
               if (rsp_last !== oldest.last)
                  report_mismatch($sformatf("last %b, awaited %b", rsp_last, oldest.last));
            end
         end
         if (req_valid && !req_stall)
            update_timer_list(stq_pkg::op_type'(req_operation), req_connection_id,
                              req_expire_time, req_now_time);
      end
      outstanding <= awaited_results.size();
      mismatches  <= mismatch_tally;
   end

endmodule

[test/tb_sorted_timeout_queue.sv]
// Testbench top of the sorted timeout queue: clock, reset, stimulus and the verdict.
module tb_sorted_timeout_queue;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is stopped by force after this many cycles. The slowest correct
   // run, with every item popping 32 timers and every result waiting out a
   // full stall burst, stays well under a third of it.
   localparam int CYCLE_LIMIT     = 2_000_000;
   // Long hold-off of the result side, so that the queue backs up into its input.
   localparam int HOLD_OFF_CYCLES = 400;
   // Cycles allowed after the last awaited result for stray results to show up.
   localparam int DRAIN_CYCLES    = 40;
   localparam int POOL_SIZE       = 48;

   logic                            clock             = 1'b0;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic                            req_stall;
   logic [1:0]                      req_operation     = stq_pkg::OP_INSERT;
   logic [stq_pkg::ID_PORT_W-1:0]   req_connection_id = '0;
   logic [stq_pkg::TIME_PORT_W-1:0] req_expire_time   = '0;
   logic [stq_pkg::TIME_PORT_W-1:0] req_now_time      = '0;
   logic                            rsp_valid;
   logic                            rsp_stall         = 1'b0;
   logic [stq_pkg::STATUS_W-1:0]    rsp_status;
   logic [stq_pkg::ID_PORT_W-1:0]   rsp_expired_id;
   logic                            rsp_last;

   int mismatches;
   int outstanding;
   int cycle_count = 0;

   // Stimulus controls; quiet_tail and hold_off_pending are shared between the sender and the receiver.
   bit                              quiet_tail       = 1'b0;
   bit                              hold_off_pending = 1'b0;
   logic [stq_pkg::TIME_PORT_W-1:0] now_base         = '0;
   logic [stq_pkg::ID_PORT_W-1:0]   conn_pool [POOL_SIZE];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sorted_timeout_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_connection_id (req_connection_id),
      .req_expire_time   (req_expire_time),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_last          (rsp_last)
   );

   stq_result_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_connection_id (req_connection_id),
      .req_expire_time   (req_expire_time),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_last          (rsp_last),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   // Watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offers one item and returns at the edge where it is taken. Now and then
   // the sender first goes idle for a random burst, except in the quiet tail.
   // The payload is only changed here, so a stalled item stays put.
   task automatic offer_request(input stq_pkg::op_type op,
                                input logic [stq_pkg::ID_PORT_W-1:0] conn,
                                input logic [stq_pkg::TIME_PORT_W-1:0] expiry,
                                input logic [stq_pkg::TIME_PORT_W-1:0] tick_time);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_connection_id <= conn;
      req_expire_time   <= expiry;
      req_now_time      <= tick_time;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Fills the list past its capacity with timers close together in time, so
   // that equal expiries and the full status both occur, then probes an id
   // that is present while the list is full (duplicate must win over full),
   // and finally drains the list with a partial tick and a tick at the end of
   // time, which pops every timer that is left in one item.
   task automatic fill_and_flush();
      for (int slot = 0; slot < 40; slot++)
         offer_request(stq_pkg::OP_INSERT, conn_pool[slot],
                       now_base + $urandom_range(0, 300), $urandom);
      offer_request(stq_pkg::OP_INSERT, conn_pool[0], $urandom, $urandom);
      offer_request(stq_pkg::OP_TICK, 16'($urandom), $urandom, now_base + 150);
      offer_request(stq_pkg::OP_TICK, 16'($urandom), $urandom, 32'hFFFF_FFFF);
      now_base += 300;
   endtask

   // Mostly well-formed traffic: ids come from a small pool so that removes
   // and adjusts usually hit a live timer, and times cluster around a slowly
   // advancing base so that ticks pop a few timers at a time. A small share
   // of fully random ids and times keeps every bit of every field moving.
   task automatic random_traffic(input int count);
      int                              pick;
      stq_pkg::op_type                 op;
      logic [stq_pkg::ID_PORT_W-1:0]   conn;
      logic [stq_pkg::TIME_PORT_W-1:0] expiry;
      logic [stq_pkg::TIME_PORT_W-1:0] tick_time;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      op = stq_pkg::OP_INSERT;
         else if (pick < 55) op = stq_pkg::OP_REMOVE;
         else if (pick < 75) op = stq_pkg::OP_ADJUST;
         else                op = stq_pkg::OP_TICK;
         conn = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                            : conn_pool[$urandom_range(0, POOL_SIZE - 1)];
         expiry = ($urandom_range(0, 6) == 0) ? $urandom : now_base + $urandom_range(0, 200);
         case ($urandom_range(0, 9))
            0: tick_time = $urandom;
            1: tick_time = now_base - $urandom_range(0, 50);
            default: tick_time = now_base + $urandom_range(0, 120);
         endcase
         offer_request(op, conn, expiry, tick_time);
         now_base += $urandom_range(0, 20);
      end
   endtask

   // Result side. It stalls in random bursts, runs free in between and for
   // the whole quiet tail, and once holds off for a long stretch while the
   // sender keeps offering items, so that the queue stops taking input.
   initial begin
      int held;
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin
      // Distinct pool ids: the low six bits are the pool index.
      for (int i = 0; i < POOL_SIZE; i++)
         conn_pool[i] = {10'($urandom_range(0, 1023)), 6'(i)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty list first: a tick finds nothing, and remove
      // and adjust of an absent id are refused.
      offer_request(stq_pkg::OP_TICK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_request(stq_pkg::OP_REMOVE, 16'hA5A5, 32'h0000_0000, 32'h0000_0000);
      offer_request(stq_pkg::OP_ADJUST, 16'h5A5A, 32'hFFFF_FFFF, 32'h0000_0000);
      // Extreme ids and times; the third insert ties with the first on expiry
      // and must land ahead of it.
      offer_request(stq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      offer_request(stq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_request(stq_pkg::OP_INSERT, 16'h1234, 32'hFFFF_FFFF, 32'h0000_0000);
      offer_request(stq_pkg::OP_INSERT, 16'hFFFF, 32'h0000_0001, 32'h0000_0000);
      offer_request(stq_pkg::OP_INSERT, 16'h5555, 32'h0000_0064, 32'h0000_0000);
      offer_request(stq_pkg::OP_ADJUST, 16'h5555, 32'hFFFF_FFFF, 32'h0000_0000);
      offer_request(stq_pkg::OP_REMOVE, 16'h1234, 32'h0000_0000, 32'h0000_0000);
      // A tick at exactly the earliest expiry pops it; one below the rest pops
      // nothing; the end of time pops everything that is left, in order.
      offer_request(stq_pkg::OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      offer_request(stq_pkg::OP_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0032);
      offer_request(stq_pkg::OP_TICK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_request(stq_pkg::OP_REMOVE, 16'hFFFF, 32'h0000_0000, 32'h0000_0000);

      now_base = $urandom;
      fill_and_flush();
      random_traffic(95);

      // Second block carries the long hold-off of the result side.
      fill_and_flush();
      hold_off_pending = 1'b1;
      random_traffic(95);

      fill_and_flush();
      random_traffic(35);
      quiet_tail = 1'b1;
      random_traffic(60);
      req_valid <= 1'b0;

      // One more edge so that the count of awaited results includes the last item.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
